### hdl/trilinear_corner_weights_unit_macros.svh
// Assertion macros for the trilinear corner weights unit.
// No dependencies; included by the top level, which carries the assertions.
`ifndef TRILINEAR_CORNER_WEIGHTS_UNIT_MACROS_SVH
`define TRILINEAR_CORNER_WEIGHTS_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, clocked on clk, quiet in reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk, quiet in reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT_NOW(lbl, ante, cons, msg)
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/tcw_pkg.sv
// Shared constants for the trilinear corner weights unit.
// No dependencies; used by tcw_axis and the top level.
package tcw_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int WT_W      = FRAC_BITS + 1;
  localparam logic [WT_W-1:0] ONE_FX = WT_W'(1) << FRAC_BITS;

  // field widths
  localparam int POS_W    = 32;
  localparam int TIME_W   = 31;
  localparam int STEP_W   = 25;
  localparam int NCFG_W   = 11;
  localparam int CELL_W   = 30;
  localparam int TIDX_W   = 16;
  localparam int TFRAC_W  = 16;
  localparam int CORNER_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_T   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_CELLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CELLS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Z_CELLS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_T_MODE  = 3'd7;

  // reset values
  localparam logic [STEP_W-1:0] INV_STEP_RST = 25'd65536;
  localparam logic [NCFG_W-1:0] CELLS_RST    = 11'd64;

endpackage

### hdl/tcw_axis.sv
// One axis: position times reciprocal spacing, then floor, cell split and wrap.
// Depends on tcw_pkg. Two register stages, each with its own load enable.
module tcw_axis #(
  parameter int MAX_AXIS_POINTS = 1024
) (
  input  logic                                       clk,
  input  logic                                       en_mul,
  input  logic                                       en_split,
  input  logic signed [tcw_pkg::POS_W-1:0]           pos,
  input  logic        [tcw_pkg::STEP_W-1:0]          inv,
  input  logic        [$clog2(MAX_AXIS_POINTS+1)-1:0] n,
  output logic        [$clog2(MAX_AXIS_POINTS)-1:0]  cell_lo_r,
  output logic        [$clog2(MAX_AXIS_POINTS)-1:0]  cell_hi_r,
  output logic        [tcw_pkg::WT_W-1:0]            frac_r,
  output logic                                       far_r
);

  localparam int AXW = $clog2(MAX_AXIS_POINTS);
  localparam int NW  = $clog2(MAX_AXIS_POINTS + 1);
  localparam int PW  = tcw_pkg::POS_W + tcw_pkg::STEP_W + 1;
  localparam int SW  = PW - tcw_pkg::FRAC_BITS;

  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  prod_nxt;
  logic signed [SW-1:0]  s;
  logic signed [SW-1:0]  top;
  logic signed [SW-1:0]  d_above;
  logic signed [SW-1:0]  d_below;
  logic        [NW-1:0]  nm1;
  logic        [NW-1:0]  lo_ext;
  logic        [NW-1:0]  hi_ext;
  logic        [AXW-1:0] lo_nxt;
  logic        [AXW-1:0] hi_nxt;
  logic [tcw_pkg::WT_W-1:0] frac_nxt;
  logic                  far_nxt;

  // scale by reciprocal spacing
  assign prod_nxt = pos * $signed({1'b0, inv});

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= prod_nxt;
    end
  end

  // floor to Q.16, split into cell and fraction, wrap at either end
  always_comb begin
    s       = prod_r[PW-1:tcw_pkg::FRAC_BITS];
    nm1     = n - NW'(1);
    top     = $signed(SW'({nm1, {tcw_pkg::FRAC_BITS{1'b0}}}));
    d_above = s - top;
    d_below = s + $signed(SW'(tcw_pkg::ONE_FX));
    lo_ext  = NW'(s[tcw_pkg::FRAC_BITS +: AXW]);
    hi_ext  = lo_ext + NW'(1);
    far_nxt = 1'b0;
    if (s > top) begin
      lo_nxt = AXW'(nm1);
      hi_nxt = '0;
      if (d_above > $signed(SW'(tcw_pkg::ONE_FX))) begin
        far_nxt  = 1'b1;
        frac_nxt = tcw_pkg::ONE_FX;
      end else begin
        frac_nxt = d_above[tcw_pkg::WT_W-1:0];
      end
    end else if (s[SW-1]) begin
      lo_nxt = AXW'(nm1);
      hi_nxt = '0;
      if (d_below[SW-1]) begin
        far_nxt  = 1'b1;
        frac_nxt = '0;
      end else begin
        frac_nxt = d_below[tcw_pkg::WT_W-1:0];
      end
    end else begin
      lo_nxt   = s[tcw_pkg::FRAC_BITS +: AXW];
      hi_nxt   = (hi_ext >= n) ? '0 : AXW'(hi_ext);
      frac_nxt = {1'b0, s[tcw_pkg::FRAC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en_split) begin
      cell_lo_r <= lo_nxt;
      cell_hi_r <= hi_nxt;
      frac_r    <= frac_nxt;
      far_r     <= far_nxt;
    end
  end

endmodule

### hdl/trilinear_corner_weights_unit.sv
// Trilinear corner weights unit: top level, pipeline control and corner sequencer.
// Depends on tcw_pkg, tcw_axis and trilinear_corner_weights_unit_macros.svh.
//
//   channel | ports                          | word
//   --------+--------------------------------+----------------------------------
//   in      | in_valid, in_stall, in_*       | position x/y/z and time
//   out     | out_valid, out_stall, out_*    | one cube corner: index and weight
//   cfg     | cfg_we, cfg_index, cfg_data    | one register write, no read-back
//
// An item yields eight words, one per cycle unless out_stall holds them, from
// the corner counter in stage 3; stages 1 and 2 can take the next item meanwhile.
// Stages: scale multiply, cell split, flat index multiply, corner weight, output.
// Sync reset clears all valid bits and corner counter, presets config registers.
// out_stall freezes the output word and backs up the stages up to in_stall.
`include "trilinear_corner_weights_unit_macros.svh"

module trilinear_corner_weights_unit #(
  parameter int MAX_AXIS_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tcw_pkg::STEP_W-1:0]           cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tcw_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [tcw_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [tcw_pkg::POS_W-1:0]     in_pos_z,
  input  logic [tcw_pkg::TIME_W-1:0]           in_time_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tcw_pkg::CORNER_W-1:0]         out_corner_number,
  output logic [tcw_pkg::CELL_W-1:0]           out_cell_index,
  output logic [tcw_pkg::WT_W-1:0]             out_weight,
  output logic [tcw_pkg::TIDX_W-1:0]           out_time_index,
  output logic [tcw_pkg::TFRAC_W-1:0]          out_time_fraction,
  output logic                                 out_out_of_range,
  output logic                                 out_last_corner
);

  localparam int AXW = $clog2(MAX_AXIS_POINTS);
  localparam int NW  = $clog2(MAX_AXIS_POINTS + 1);
  localparam int NNW = 2 * NW;
  localparam int EW  = (NW > tcw_pkg::NCFG_W) ? NW : tcw_pkg::NCFG_W;
  localparam int TPW = tcw_pkg::TIME_W + tcw_pkg::STEP_W;
  localparam int MPW = 2 * tcw_pkg::WT_W;
  localparam int FB  = tcw_pkg::FRAC_BITS;
  localparam int CW  = tcw_pkg::CELL_W;
  localparam int WW  = tcw_pkg::WT_W;

  // configuration registers
  logic [tcw_pkg::STEP_W-1:0] inv_x_r, inv_y_r, inv_z_r, inv_t_r;
  logic [tcw_pkg::NCFG_W-1:0] x_cells_r, y_cells_r, z_cells_r;
  logic                       time_mode_r;

  // clamped axis sizes
  logic [NW-1:0]  nx, ny, nz;
  logic [NNW-1:0] nynx_r;

  // handshake chain
  logic rdy_out, rdy_c1, rdy_s3, rdy_s2, rdy_s1, emit;
  logic s1_v_r, s2_v_r, s3_v_r, c1_v_r, out_v_r;

  // stage 1/2 time path
  logic [TPW-1:0]                  tp_r;
  logic [tcw_pkg::TIDX_W-1:0]      s2_tidx_r;
  logic [tcw_pkg::TFRAC_W-1:0]     s2_tfrac_r;

  // axis outputs (stage 2)
  logic [AXW-1:0] xlo, xhi, ylo, yhi, zlo, zhi;
  logic [WW-1:0]  dx, dy, dz;
  logic           farx, fary, farz;

  // stage 3: item held for its eight corners
  logic [CW-1:0]                   z0_r, z1_r, y0_r, y1_r;
  logic [AXW-1:0]                  xlo_r, xhi_r;
  logic [WW-1:0]                   dx_r, dy_r, dz_r;
  logic                            far_r;
  logic [tcw_pkg::TIDX_W-1:0]      s3_tidx_r;
  logic [tcw_pkg::TFRAC_W-1:0]     s3_tfrac_r;
  logic [tcw_pkg::CORNER_W-1:0]    cnt_r;

  // corner stage
  logic [WW-1:0]                   wx, wy, wz;
  logic [MPW-1:0]                  pxy_full;
  logic [CW-1:0]                   flat;
  logic [tcw_pkg::CORNER_W-1:0]    c1_corner_r;
  logic [WW-1:0]                   c1_pxy_r, c1_wz_r;
  logic [CW-1:0]                   c1_flat_r;
  logic [tcw_pkg::TIDX_W-1:0]      c1_tidx_r;
  logic [tcw_pkg::TFRAC_W-1:0]     c1_tfrac_r;
  logic                            c1_far_r;
  logic [MPW-1:0]                  w_full;

  // output register
  logic [tcw_pkg::CORNER_W-1:0]    out_corner_r;
  logic [CW-1:0]                   out_cell_r;
  logic [WW-1:0]                   out_weight_r;
  logic [tcw_pkg::TIDX_W-1:0]      out_tidx_r;
  logic [tcw_pkg::TFRAC_W-1:0]     out_tfrac_r;
  logic                            out_far_r;
  logic                            out_last_r;

  function automatic logic [NW-1:0] clamp_n(input logic [tcw_pkg::NCFG_W-1:0] c);
    logic [EW-1:0] e;
    e = EW'(c);
    if (e < EW'(2)) begin
      return NW'(2);
    end else if (e > EW'(MAX_AXIS_POINTS)) begin
      return NW'(MAX_AXIS_POINTS);
    end
    return NW'(e);
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r     <= tcw_pkg::INV_STEP_RST;
      inv_y_r     <= tcw_pkg::INV_STEP_RST;
      inv_z_r     <= tcw_pkg::INV_STEP_RST;
      inv_t_r     <= tcw_pkg::INV_STEP_RST;
      x_cells_r   <= tcw_pkg::CELLS_RST;
      y_cells_r   <= tcw_pkg::CELLS_RST;
      z_cells_r   <= tcw_pkg::CELLS_RST;
      time_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcw_pkg::REG_INV_X:   inv_x_r     <= cfg_data;
        tcw_pkg::REG_INV_Y:   inv_y_r     <= cfg_data;
        tcw_pkg::REG_INV_Z:   inv_z_r     <= cfg_data;
        tcw_pkg::REG_INV_T:   inv_t_r     <= cfg_data;
        tcw_pkg::REG_X_CELLS: x_cells_r   <= cfg_data[tcw_pkg::NCFG_W-1:0];
        tcw_pkg::REG_Y_CELLS: y_cells_r   <= cfg_data[tcw_pkg::NCFG_W-1:0];
        tcw_pkg::REG_Z_CELLS: z_cells_r   <= cfg_data[tcw_pkg::NCFG_W-1:0];
        tcw_pkg::REG_T_MODE:  time_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // axis sizes and the plane size, refreshed every cycle
  assign nx = clamp_n(x_cells_r);
  assign ny = clamp_n(y_cells_r);
  assign nz = clamp_n(z_cells_r);

  always_ff @(posedge clk) begin
    nynx_r <= NNW'(ny) * NNW'(nx);
  end

  // ready chain, back from the output register
  assign rdy_out  = !out_v_r || !out_stall;
  assign rdy_c1   = !c1_v_r || rdy_out;
  assign emit     = s3_v_r && rdy_c1;
  assign rdy_s3   = !s3_v_r || (emit && (cnt_r == tcw_pkg::LAST_CORNER));
  assign rdy_s2   = !s2_v_r || rdy_s3;
  assign rdy_s1   = !s1_v_r || rdy_s2;
  assign in_stall = !rdy_s1;

  // valid bits and corner counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      c1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (rdy_s1)  s1_v_r  <= in_valid;
      if (rdy_s2)  s2_v_r  <= s1_v_r;
      if (rdy_s3)  s3_v_r  <= s2_v_r;
      if (rdy_c1)  c1_v_r  <= emit;
      if (rdy_out) out_v_r <= c1_v_r;
      if (emit)    cnt_r   <= cnt_r + tcw_pkg::CORNER_W'(1);
    end
  end

  // stages 1 and 2 per axis
  tcw_axis #(.MAX_AXIS_POINTS(MAX_AXIS_POINTS)) u_axis_x (
    .clk(clk), .en_mul(rdy_s1), .en_split(rdy_s2), .pos(in_pos_x), .inv(inv_x_r),
    .n(nx), .cell_lo_r(xlo), .cell_hi_r(xhi), .frac_r(dx), .far_r(farx)
  );
  tcw_axis #(.MAX_AXIS_POINTS(MAX_AXIS_POINTS)) u_axis_y (
    .clk(clk), .en_mul(rdy_s1), .en_split(rdy_s2), .pos(in_pos_y), .inv(inv_y_r),
    .n(ny), .cell_lo_r(ylo), .cell_hi_r(yhi), .frac_r(dy), .far_r(fary)
  );
  tcw_axis #(.MAX_AXIS_POINTS(MAX_AXIS_POINTS)) u_axis_z (
    .clk(clk), .en_mul(rdy_s1), .en_split(rdy_s2), .pos(in_pos_z), .inv(inv_z_r),
    .n(nz), .cell_lo_r(zlo), .cell_hi_r(zhi), .frac_r(dz), .far_r(farz)
  );

  // time: scale, then split with saturation, or zero when time mode is off
  always_ff @(posedge clk) begin
    if (rdy_s1) begin
      tp_r <= TPW'(in_time_value) * TPW'(inv_t_r);
    end
    if (rdy_s2) begin
      if (!time_mode_r) begin
        s2_tidx_r  <= '0;
        s2_tfrac_r <= '0;
      end else if (|tp_r[TPW-1:2*FB+tcw_pkg::TIDX_W]) begin
        s2_tidx_r  <= '1;
        s2_tfrac_r <= '1;
      end else begin
        s2_tidx_r  <= tp_r[2*FB +: tcw_pkg::TIDX_W];
        s2_tfrac_r <= tp_r[FB +: tcw_pkg::TFRAC_W];
      end
    end
  end

  // stage 3: row and plane offsets of the lower and upper cells
  always_ff @(posedge clk) begin
    if (rdy_s3) begin
      z0_r       <= CW'(zlo) * CW'(nynx_r);
      z1_r       <= CW'(zhi) * CW'(nynx_r);
      y0_r       <= CW'(ylo) * CW'(nx);
      y1_r       <= CW'(yhi) * CW'(nx);
      xlo_r      <= xlo;
      xhi_r      <= xhi;
      dx_r       <= dx;
      dy_r       <= dy;
      dz_r       <= dz;
      far_r      <= farx || fary || farz;
      s3_tidx_r  <= s2_tidx_r;
      s3_tfrac_r <= s2_tfrac_r;
    end
  end

  // corner select: axis factors, xy product and flat index
  always_comb begin
    wx       = cnt_r[0] ? dx_r : tcw_pkg::ONE_FX - dx_r;
    wy       = cnt_r[1] ? dy_r : tcw_pkg::ONE_FX - dy_r;
    wz       = cnt_r[2] ? dz_r : tcw_pkg::ONE_FX - dz_r;
    pxy_full = MPW'(wx) * MPW'(wy);
    flat     = (cnt_r[2] ? z1_r : z0_r) + (cnt_r[1] ? y1_r : y0_r)
             + CW'(cnt_r[0] ? xhi_r : xlo_r);
  end

  always_ff @(posedge clk) begin
    if (rdy_c1) begin
      c1_corner_r <= cnt_r;
      c1_pxy_r    <= pxy_full[FB +: WW];
      c1_wz_r     <= wz;
      c1_flat_r   <= flat;
      c1_tidx_r   <= s3_tidx_r;
      c1_tfrac_r  <= s3_tfrac_r;
      c1_far_r    <= far_r;
    end
  end

  // output word: final weight product
  assign w_full = MPW'(c1_pxy_r) * MPW'(c1_wz_r);

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_corner_r <= c1_corner_r;
      out_cell_r   <= c1_flat_r;
      out_weight_r <= w_full[FB +: WW];
      out_tidx_r   <= c1_tidx_r;
      out_tfrac_r  <= c1_tfrac_r;
      out_far_r    <= c1_far_r;
      out_last_r   <= (c1_corner_r == tcw_pkg::LAST_CORNER);
    end
  end

  assign out_valid         = out_v_r;
  assign out_corner_number = out_corner_r;
  assign out_cell_index    = out_cell_r;
  assign out_weight        = out_weight_r;
  assign out_time_index    = out_tidx_r;
  assign out_time_fraction = out_tfrac_r;
  assign out_out_of_range  = out_far_r;
  assign out_last_corner   = out_last_r;

  // checks
  `TCW_ASSERT_NOW(a_idle_cnt_zero, !s3_v_r, cnt_r == '0, "corner counter off zero with no item")
  `TCW_ASSERT_NEXT(a_item_held, emit && (cnt_r != tcw_pkg::LAST_CORNER), s3_v_r, "item dropped before last corner")
  `TCW_ASSERT_NOW(a_last_flag, out_v_r && out_last_r, out_corner_r == tcw_pkg::LAST_CORNER, "last flag on wrong corner")
  `TCW_ASSERT_NOW(a_weight_max, out_v_r, out_weight_r <= tcw_pkg::ONE_FX, "weight above one")

endmodule
